FILE: sv/ssji_pkg.sv
package ssji_pkg;

    localparam int MAX_SET_SIZE = 1024;
    localparam int ADDR_W       = $clog2(MAX_SET_SIZE);
    localparam int CNT_W        = ADDR_W + 1;

    localparam int HASH_W       = 64;
    localparam int COMMON_W     = 11;
    localparam int UNION_W      = 12;
    localparam int SIM_W        = 17;
    localparam int THR_W        = 17;
    localparam int STATUS_W     = 2;

    localparam int DIV_STEPS    = SIM_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS);
    localparam int REM_W        = UNION_W + 1;

    localparam logic [THR_W-1:0]    THR_RESET   = THR_W'(32768);

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    typedef struct packed {
        logic accept;
        logic wp_inc;
        logic match_inc;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic probe_full;
        logic wp_lt_ref;
        logic rd_lt;
        logic rd_eq;
        logic div_last;
    } t_stat;

endpackage

FILE: sv/ssji_datapath.sv
module ssji_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ssji_pkg::t_cmd                  i_cmd,
    output ssji_pkg::t_stat                 o_stat,
    input  logic [ssji_pkg::HASH_W-1:0]     i_hash_value,
    input  logic                            i_set_select,
    input  logic                            i_cfg_valid,
    input  logic [ssji_pkg::THR_W-1:0]      i_min_similarity,
    output logic [ssji_pkg::COMMON_W-1:0]   o_common_count,
    output logic [ssji_pkg::UNION_W-1:0]    o_union_count,
    output logic [ssji_pkg::SIM_W-1:0]      o_similarity,
    output logic                            o_is_match,
    output logic [ssji_pkg::STATUS_W-1:0]   o_status
);
    import ssji_pkg::*;

    logic [HASH_W-1:0]   r_store [MAX_SET_SIZE];
    logic [HASH_W-1:0]   r_rdata;
    logic [HASH_W-1:0]   r_hash;
    logic [THR_W-1:0]    r_thr;

    logic [CNT_W-1:0]    r_ref_count, n_ref_count;
    logic [CNT_W-1:0]    r_probe_count, n_probe_count;
    logic [CNT_W-1:0]    r_match_count, n_match_count;
    logic [CNT_W-1:0]    r_wp, n_wp;
    logic                r_ovf, n_ovf;

    logic [REM_W-1:0]    r_rem, n_rem;
    logic [SIM_W-1:0]    r_quo, n_quo;
    logic [DCNT_W-1:0]   r_dcnt, n_dcnt;

    logic [COMMON_W-1:0] r_common;
    logic [UNION_W-1:0]  r_union;
    logic [SIM_W-1:0]    r_sim;
    logic                r_is_match;
    logic [STATUS_W-1:0] r_status;

    logic                ref_full;
    logic                store_wr;
    logic [UNION_W-1:0]  union_sum;
    logic                div_ge;
    logic [REM_W-1:0]    div_diff;
    logic [SIM_W-1:0]    sim_val;
    logic [STATUS_W-1:0] status_val;

    assign ref_full  = (r_ref_count == CNT_W'(MAX_SET_SIZE));
    assign store_wr  = i_cmd.accept && !i_set_select && !ref_full;
    assign union_sum = UNION_W'(r_probe_count) + UNION_W'(r_ref_count)
                     - UNION_W'(r_match_count);

    // restoring divider, one quotient bit per step
    assign div_ge   = (r_rem >= REM_W'(union_sum));
    assign div_diff = r_rem - REM_W'(union_sum);

    assign sim_val = (union_sum == '0) ? '0 : r_quo;

    always_comb begin
        if (r_ovf) begin
            status_val = ST_OVERFLOW;
        end else if (r_probe_count == '0 || r_ref_count == '0) begin
            status_val = ST_EMPTY;
        end else begin
            status_val = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_wr) begin
            r_store[r_ref_count[ADDR_W-1:0]] <= i_hash_value;
        end
        r_rdata <= r_store[r_wp[ADDR_W-1:0]];
    end

    always_comb begin
        n_ref_count   = r_ref_count;
        n_probe_count = r_probe_count;
        n_match_count = r_match_count;
        n_wp          = r_wp;
        n_ovf         = r_ovf;
        if (i_cmd.accept) begin
            if (i_set_select) begin
                if (o_stat.probe_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_probe_count = r_probe_count + 1'b1;
                end
            end else begin
                if (ref_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_ref_count = r_ref_count + 1'b1;
                end
            end
        end
        if (i_cmd.wp_inc) begin
            n_wp = r_wp + 1'b1;
        end
        if (i_cmd.match_inc) begin
            n_match_count = r_match_count + 1'b1;
        end
        if (i_cmd.load_out) begin
            n_ref_count   = '0;
            n_probe_count = '0;
            n_match_count = '0;
            n_wp          = '0;
            n_ovf         = 1'b0;
        end
    end

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dcnt = r_dcnt;
        if (i_cmd.div_init) begin
            n_rem  = REM_W'(r_match_count);
            n_quo  = '0;
            n_dcnt = DCNT_W'(DIV_STEPS - 1);
        end else if (i_cmd.div_step) begin
            n_rem  = {(div_ge ? div_diff[REM_W-2:0] : r_rem[REM_W-2:0]), 1'b0};
            n_quo  = {r_quo[SIM_W-2:0], div_ge};
            n_dcnt = r_dcnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_count   <= '0;
            r_probe_count <= '0;
            r_match_count <= '0;
            r_wp          <= '0;
            r_ovf         <= 1'b0;
            r_thr         <= THR_RESET;
        end else begin
            r_ref_count   <= n_ref_count;
            r_probe_count <= n_probe_count;
            r_match_count <= n_match_count;
            r_wp          <= n_wp;
            r_ovf         <= n_ovf;
            if (i_cfg_valid) begin
                r_thr <= i_min_similarity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_dcnt <= n_dcnt;
        if (i_cmd.accept) begin
            r_hash <= i_hash_value;
        end
        if (i_cmd.load_out) begin
            r_common   <= COMMON_W'(r_match_count);
            r_union    <= union_sum;
            r_sim      <= sim_val;
            r_is_match <= (status_val != ST_EMPTY) && (sim_val >= r_thr);
            r_status   <= status_val;
        end
    end

    assign o_stat.probe_full = (r_probe_count == CNT_W'(MAX_SET_SIZE));
    assign o_stat.wp_lt_ref  = (r_wp < r_ref_count);
    assign o_stat.rd_lt      = (r_rdata < r_hash);
    assign o_stat.rd_eq      = (r_rdata == r_hash);
    assign o_stat.div_last   = (r_dcnt == '0);

    assign o_common_count = r_common;
    assign o_union_count  = r_union;
    assign o_similarity   = r_sim;
    assign o_is_match     = r_is_match;
    assign o_status       = r_status;

endmodule

FILE: sv/ssji_ctrl.sv
module ssji_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic             i_set_select,
    input  logic             i_last,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  ssji_pkg::t_stat  i_stat,
    output ssji_pkg::t_cmd   o_cmd
);
    import ssji_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIVI = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_out_valid, n_out_valid;
    logic       in_xfer;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_last  = r_last;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.accept = 1'b1;
                    n_last       = i_last;
                    if (i_set_select && !i_stat.probe_full) begin
                        n_state = S_RD;
                    end else if (i_last) begin
                        n_state = S_DIVI;
                    end
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_stat.wp_lt_ref && i_stat.rd_lt) begin
                    o_cmd.wp_inc = 1'b1;
                    n_state      = S_RD;
                end else begin
                    if (i_stat.wp_lt_ref && i_stat.rd_eq) begin
                        o_cmd.wp_inc    = 1'b1;
                        o_cmd.match_inc = 1'b1;
                    end
                    n_state = r_last ? S_DIVI : S_IDLE;
                end
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/sorted_set_jaccard_index_unit.sv
// Jaccard index of two sorted, duplicate-free sets of 64-bit hashes. Send the
// reference set (set_select 0) into the 1024-entry store, then the probe set
// (set_select 1) in ascending order; the element with last set closes the pair
// and yields one result with common and union counts, the Q1.16 ratio, the
// threshold flag and a status, after which all counts clear for the next pair.
// A reference element is stored on acceptance while the store has room. A probe
// element walks the store forward, each skipped entry taking a registered store
// read and a compare, or only flags overflow once the probe set is full. Closing
// a pair runs the bit-serial divider and the output load; a result waits in the
// output register until it is taken, and the next pair's items are accepted
// meanwhile, but a pair that closes before then stalls in the output load.
module sorted_set_jaccard_index_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [ssji_pkg::HASH_W-1:0]     i_hash_value,
    input  logic                            i_set_select,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [ssji_pkg::COMMON_W-1:0]   o_common_count,
    output logic [ssji_pkg::UNION_W-1:0]    o_union_count,
    output logic [ssji_pkg::SIM_W-1:0]      o_similarity,
    output logic                            o_is_match,
    output logic [ssji_pkg::STATUS_W-1:0]   o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ssji_pkg::THR_W-1:0]      i_min_similarity
);
    import ssji_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    ssji_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_set_select (i_set_select),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_stat       (stat),
        .o_cmd        (cmd)
    );

    ssji_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_hash_value     (i_hash_value),
        .i_set_select     (i_set_select),
        .i_cfg_valid      (i_cfg_valid),
        .i_min_similarity (i_min_similarity),
        .o_common_count   (o_common_count),
        .o_union_count    (o_union_count),
        .o_similarity     (o_similarity),
        .o_is_match       (o_is_match),
        .o_status         (o_status)
    );

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_EMPTY
                         || o_status == ST_OVERFLOW))
        else $error("bad status code");

    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_similarity <= SIM_W'(65536)))
        else $error("similarity above one");

    a_common_le_union: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (UNION_W'(o_common_count) <= o_union_count))
        else $error("common count above union count");

    a_empty_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_EMPTY) |-> !o_is_match)
        else $error("match flagged on empty set");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept) |=> !o_in_ready || !stat.probe_full || !$past(i_set_select)
                         || $past(stat.probe_full))
        else $error("probe counter passed the set limit");

endmodule
